>>> hdl/ssse_pkg.sv
// ============================================================================
// ssse_pkg
// Shared widths, codes, command/status bundles and helpers for the
// segmented space symbol encoder.
// ============================================================================
package ssse_pkg;

    // Default values of the top-level parameters
    localparam int MAX_AXES_DEF    = 3;
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int MAX_CHUNKS_DEF  = 512;
    localparam int MAX_LEVELS_DEF  = 16;

    // Number of vector lanes carried on the ports
    localparam int AXES_N = 3;

    // Port widths
    localparam int IN_W   = 136;
    localparam int OUT_W  = 72;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // Field widths
    localparam int IDX_W  = 12;
    localparam int CNT_W  = 16;
    localparam int LINK_W = 12;
    localparam int VAL_W  = 32;
    localparam int TOT_W  = 25;
    localparam int LOW_W  = 24;
    localparam int FREQ_W = 16;

    // Internal widths
    localparam int SIZE_W = 25;     // cell edge
    localparam int CEN_W  = 33;     // centered value
    localparam int EXT_W  = 35;     // cell start and search bounds
    localparam int PC_W   = 7;      // entries per chunk, up to 64
    localparam int BASE_W = 19;     // chunk times entries per chunk
    localparam int AX_W   = 2;
    localparam int STEP_W = 3;
    localparam int CC_W   = 13;
    localparam int ENTRY_W = CNT_W + CNT_W + LINK_W;

    // Load index divider: one quotient bit per cycle
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(IDX_W - 1);

    // Exact divide by three for values below 2**25: (x * M) >> 26
    localparam int DIV3_W     = 26;
    localparam int DIV3_SHIFT = 26;
    localparam logic [DIV3_W-1:0] DIV3_MUL = 26'd22369622;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_AXIS_COUNT  = 3'd0,
        REG_SPLIT_STEPS = 3'd1,
        REG_OUTER_SIZE  = 3'd2,
        REG_CHUNK_COUNT = 3'd3,
        REG_CENTER_X    = 3'd4,
        REG_CENTER_Y    = 3'd5,
        REG_CENTER_Z    = 3'd6
    } cfg_reg_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LDIV,
        ST_LWRITE,
        ST_CENTER,
        ST_RANGE,
        ST_OOR,
        ST_CHECK,
        ST_EMIT,
        ST_DIV,
        ST_SEARCH,
        ST_ADDR,
        ST_NEXT,
        ST_RESID
    } state_t;

    // Source of an output result
    typedef enum logic [1:0] {
        OSEL_OOR,
        OSEL_SYM,
        OSEL_RES
    } out_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     accept;
        logic     ldiv_step;
        logic     load_write;
        logic     center;
        logic     init;
        logic     check;
        logic     div;
        logic     search;
        logic     next;
        logic     res_step;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
    } ssse_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic in_ok;
        logic cont;
        logic size_gt1;
        logic res_last;
        logic out_free;
    } ssse_stat_t;

    // Entries per chunk: steps raised to the number of axes
    function automatic logic [PC_W-1:0] ssse_per_chunk(input logic [STEP_W-1:0] s,
                                                       input logic [AX_W-1:0] a);
        logic [PC_W-1:0] s7;
        logic [PC_W-1:0] r;
        s7 = PC_W'(s);
        case (a)
            2'd2:    r = PC_W'(s7 * s7);
            2'd3:    r = PC_W'(s7 * s7 * s7);
            default: r = s7;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/segmented_space_symbol_encoder.sv
// ============================================================================
// segmented_space_symbol_encoder
// Turns an integer vector into arithmetic-coder symbols by descending a
// grid tree held in table memory; load requests fill the table.
// ============================================================================
// Load request: capture, index divider, table write. Encode request:
// centering, range check, check and emit, then per further tree level edge
// divide, cell search, table read, link follow, check, emit; then one
// residual symbol per active axis. Out of range answers with one result.
// One request at a time; the output register lets the next request start.
// Reset restores register defaults and clears the running low; the table
// memories are not cleared and must be loaded before use.
module segmented_space_symbol_encoder
    import ssse_pkg::*;
#(
    parameter int MAX_AXES    = MAX_AXES_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF,
    parameter int MAX_LEVELS  = MAX_LEVELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    // request stream
    input  logic              s_tvalid,
    output logic              s_tready,
    // entry_index, entry_count, entry_link, value_x, value_y, value_z
    input  logic [IN_W-1:0]   s_tdata,
    // op
    input  logic              s_tuser,
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    // sym_total, sym_low, sym_freq, in_range, zero pad
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast
);

    ssse_cmd_t  cmd;
    ssse_stat_t stat;

    ssse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssse_datapath #(
        .MAX_AXES    (MAX_AXES),
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_CHUNKS  (MAX_CHUNKS),
        .MAX_LEVELS  (MAX_LEVELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

    // a result is only loaded when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a pending result");

    // one request at a time: not ready right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    // an out-of-range answer is always the final result
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[65]) |-> m_tlast)
        else $error("out-of-range result without last");

endmodule

>>> hdl/ssse_ram.sv
// ============================================================================
// ssse_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ssse_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ssse_ctrl.sv
// ============================================================================
// ssse_ctrl
// Sequencer for load and encode requests: drives the datapath one step
// at a time and decides when results go out.
// ============================================================================
module ssse_ctrl
    import ssse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    input  ssse_stat_t stat,
    output ssse_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   have_sym_reg, have_sym_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            have_sym_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            have_sym_reg <= have_sym_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        have_sym_next = have_sym_reg;
        cmd           = '0;
        cmd.out_sel   = OSEL_SYM;
        s_tready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = s_tuser ? ST_CENTER : ST_LDIV;
                end
            end
            ST_LDIV:
            begin
                cmd.ldiv_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_LWRITE;
                end
            end
            ST_LWRITE:
            begin
                cmd.load_write = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_CENTER:
            begin
                cmd.center = 1'b1;
                state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                if (stat.in_ok)
                begin
                    cmd.init      = 1'b1;
                    have_sym_next = 1'b0;
                    state_next    = ST_CHECK;
                end
                else
                begin
                    state_next = ST_OOR;
                end
            end
            ST_OOR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_OOR;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // previous level's symbol goes out once the next step is known
                if (!have_sym_reg || stat.out_free)
                begin
                    cmd.out_load = have_sym_reg;
                    cmd.out_sel  = OSEL_SYM;
                    cmd.out_last = !stat.cont && !stat.size_gt1;
                    priority if (stat.cont)
                        state_next = ST_DIV;
                    else if (stat.size_gt1)
                        state_next = ST_RESID;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                cmd.next      = 1'b1;
                have_sym_next = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_RESID:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_RES;
                    cmd.out_last = stat.res_last;
                    cmd.res_step = 1'b1;
                    if (stat.res_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ssse_datapath.sv
// ============================================================================
// ssse_datapath
// Configuration registers, table memories, load divider, cell search and
// the output register of the segmented space symbol encoder.
// ============================================================================
module ssse_datapath
    import ssse_pkg::*;
#(
    parameter int MAX_AXES    = MAX_AXES_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF,
    parameter int MAX_LEVELS  = MAX_LEVELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast,
    input  ssse_cmd_t         cmd,
    output ssse_stat_t        stat
);

    localparam int TAB_AW = $clog2(TABLE_DEPTH);
    localparam int CH_AW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int LVL_W  = $clog2(MAX_LEVELS + 1);

    // configuration registers
    logic [AX_W-1:0]   axis_count_reg;
    logic [STEP_W-1:0] split_steps_reg;
    logic [SIZE_W-1:0] outer_size_reg;
    logic [CC_W-1:0]   chunk_count_reg;
    logic [VAL_W-1:0]  center_reg [AXES_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_count_reg  <= AX_W'(3);
            split_steps_reg <= STEP_W'(2);
            outer_size_reg  <= SIZE_W'(1024);
            chunk_count_reg <= CC_W'(1);
            for (int i = 0; i < AXES_N; i++)
            begin
                center_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AXIS_COUNT:  axis_count_reg  <= cfg_data[AX_W-1:0];
                REG_SPLIT_STEPS: split_steps_reg <= cfg_data[STEP_W-1:0];
                REG_OUTER_SIZE:  outer_size_reg  <= cfg_data[SIZE_W-1:0];
                REG_CHUNK_COUNT: chunk_count_reg <= cfg_data[CC_W-1:0];
                REG_CENTER_X:    center_reg[0]   <= cfg_data;
                REG_CENTER_Y:    center_reg[1]   <= cfg_data;
                REG_CENTER_Z:    center_reg[2]   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // clamped configuration
    logic [AX_W-1:0]   axes_eff;
    logic [STEP_W-1:0] steps_eff;
    logic [SIZE_W-1:0] outer_eff;
    logic [SIZE_W-1:0] half;
    logic [PC_W-1:0]   pc;
    logic [PC_W-1:0]   fac1;
    logic [PC_W-1:0]   fac2;

    always_comb
    begin
        priority if (axis_count_reg == '0)
            axes_eff = AX_W'(1);
        else if (axis_count_reg > AX_W'(MAX_AXES))
            axes_eff = AX_W'(MAX_AXES);
        else
            axes_eff = axis_count_reg;

        priority if (split_steps_reg < STEP_W'(2))
            steps_eff = STEP_W'(2);
        else if (split_steps_reg > STEP_W'(4))
            steps_eff = STEP_W'(4);
        else
            steps_eff = split_steps_reg;

        outer_eff = (outer_size_reg < SIZE_W'(2)) ? SIZE_W'(2) : outer_size_reg;
        half      = outer_eff >> 1;
        pc        = ssse_per_chunk(steps_eff, axes_eff);
        fac1      = PC_W'(steps_eff);
        fac2      = PC_W'(fac1 * fac1);
    end

    // request capture
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  cnt_in_reg;
    logic [LINK_W-1:0] link_in_reg;
    logic [VAL_W-1:0]  val_reg [AXES_N];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg     <= s_tdata[11:0];
            cnt_in_reg  <= s_tdata[27:12];
            link_in_reg <= s_tdata[39:28];
            val_reg[0]  <= s_tdata[71:40];
            val_reg[1]  <= s_tdata[103:72];
            val_reg[2]  <= s_tdata[135:104];
        end
    end

    // restoring divider: index into chunk (quotient) and cell (remainder)
    logic [PC_W-1:0]      rem_reg;
    logic [IDX_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [PC_W:0]        trial;
    logic                 qbit;

    always_comb
    begin
        trial = {rem_reg, quo_reg[IDX_W-1]};
        qbit  = (trial >= {1'b0, pc});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rem_reg  <= '0;
            quo_reg  <= s_tdata[11:0];
            dcnt_reg <= '0;
        end
        else if (cmd.ldiv_step)
        begin
            rem_reg  <= qbit ? PC_W'(trial - {1'b0, pc}) : trial[PC_W-1:0];
            quo_reg  <= {quo_reg[IDX_W-2:0], qbit};
            dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
        end
    end

    // running low of the chunk being loaded
    logic [CNT_W-1:0] run_low_reg;
    logic [CNT_W-1:0] ld_low;
    logic [CNT_W:0]   ld_sum;
    logic [CNT_W-1:0] ld_new;
    logic             idx_in_table;
    logic             chunk_in_totals;

    always_comb
    begin
        ld_low          = (rem_reg == '0) ? '0 : run_low_reg;
        ld_sum          = {1'b0, ld_low} + {1'b0, cnt_in_reg};
        ld_new          = ld_sum[CNT_W] ? '1 : ld_sum[CNT_W-1:0];
        idx_in_table    = (32'(idx_reg) < 32'(TABLE_DEPTH));
        chunk_in_totals = (32'(quo_reg) < 32'(MAX_CHUNKS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_low_reg <= '0;
        end
        else if (cmd.load_write && idx_in_table)
        begin
            run_low_reg <= ld_new;
        end
    end

    // descent state
    logic signed [CEN_W-1:0] c_reg   [AXES_N];
    logic signed [EXT_W-1:0] ext_reg [AXES_N];
    logic [SIZE_W-1:0]       size_reg;
    logic [LINK_W-1:0]       chunk_reg;
    logic [LVL_W-1:0]        lvl_reg;
    logic [BASE_W-1:0]       base_reg;
    logic                    cont_reg;
    logic [PC_W-1:0]         ofs_reg;
    logic [AX_W-1:0]         res_axis_reg;
    logic [CNT_W-1:0]        sym_tot_reg;
    logic [CNT_W-1:0]        sym_low_reg;
    logic [FREQ_W-1:0]       sym_freq_reg;

    // memories
    logic [ENTRY_W-1:0] tab_rd;
    logic [CNT_W-1:0]   tot_rd;
    logic [BASE_W-1:0]  entry_addr;

    assign entry_addr = base_reg + BASE_W'(ofs_reg);

    ssse_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_cell_table (
        .clk   (clk),
        .we    (cmd.load_write && idx_in_table),
        .waddr (TAB_AW'(idx_reg)),
        .wdata ({link_in_reg, cnt_in_reg, ld_low}),
        .raddr (TAB_AW'(entry_addr)),
        .rdata (tab_rd)
    );

    ssse_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_CHUNKS)
    ) u_chunk_totals (
        .clk   (clk),
        .we    (cmd.load_write && idx_in_table && chunk_in_totals),
        .waddr (CH_AW'(quo_reg)),
        .wdata (ld_new),
        .raddr (CH_AW'(chunk_reg)),
        .rdata (tot_rd)
    );

    // range check on the centered vector
    logic in_ok;
    always_comb
    begin
        logic signed [EXT_W-1:0] h;
        logic signed [EXT_W-1:0] cv;
        h     = signed'(EXT_W'(half));
        in_ok = 1'b1;
        for (int i = 0; i < AXES_N; i++)
        begin
            cv = EXT_W'(c_reg[i]);
            if ((i < 32'(axes_eff)) && !((cv > -h) && (cv <= h)))
            begin
                in_ok = 1'b0;
            end
        end
    end

    // continuation test for the current chunk
    logic [BASE_W-1:0] base_now;
    logic              cont_now;
    always_comb
    begin
        base_now = BASE_W'({7'b0, chunk_reg} * {12'b0, pc});
        cont_now = (lvl_reg < LVL_W'(MAX_LEVELS))
                && ({1'b0, chunk_reg} < chunk_count_reg)
                && (32'(chunk_reg) < 32'(MAX_CHUNKS))
                && ((32'(base_now) + 32'(pc)) <= 32'(TABLE_DEPTH));
    end

    // cell edge for the next level
    logic [SIZE_W+DIV3_W-1:0] div3_prod;
    logic [SIZE_W-1:0]        size_div;
    always_comb
    begin
        div3_prod = {{DIV3_W{1'b0}}, size_reg} * {{SIZE_W{1'b0}}, DIV3_MUL};
        unique case (steps_eff)
            STEP_W'(3): size_div = div3_prod[DIV3_SHIFT +: SIZE_W];
            STEP_W'(4): size_div = size_reg >> 2;
            default:    size_div = size_reg >> 1;
        endcase
    end

    // sub-cell search, one lane per axis
    logic [1:0]              sel_j   [AXES_N];
    logic signed [EXT_W-1:0] ext_new [AXES_N];
    logic [PC_W-1:0]         ofs_new;
    always_comb
    begin
        logic signed [EXT_W-1:0] size_s;
        logic signed [EXT_W-1:0] cv;
        logic signed [EXT_W-1:0] bound;
        logic                    found;
        size_s = signed'(EXT_W'(size_reg));
        for (int i = 0; i < AXES_N; i++)
        begin
            cv       = EXT_W'(c_reg[i]);
            sel_j[i] = '0;
            found    = 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                bound = ext_reg[i] + size_s * signed'(EXT_W'(k + 1));
                if (!found && (k < 32'(steps_eff)) && (cv < bound))
                begin
                    found    = 1'b1;
                    sel_j[i] = 2'(k);
                end
            end
            if (i >= 32'(axes_eff))
            begin
                sel_j[i] = '0;
            end
            ext_new[i] = ext_reg[i] + size_s * signed'(EXT_W'(sel_j[i]));
        end
        ofs_new = PC_W'(sel_j[0]) + PC_W'(fac1 * PC_W'(sel_j[1]))
                + PC_W'(fac2 * PC_W'(sel_j[2]));
    end

    // descent registers
    always_ff @(posedge clk)
    begin
        if (cmd.center)
        begin
            for (int i = 0; i < AXES_N; i++)
            begin
                c_reg[i] <= signed'({val_reg[i][VAL_W-1], val_reg[i]})
                          - signed'({center_reg[i][VAL_W-1], center_reg[i]});
            end
        end
        if (cmd.init)
        begin
            for (int i = 0; i < AXES_N; i++)
            begin
                ext_reg[i] <= -signed'(EXT_W'(half));
            end
            size_reg     <= outer_eff;
            chunk_reg    <= '0;
            lvl_reg      <= '0;
            res_axis_reg <= '0;
        end
        if (cmd.check)
        begin
            base_reg <= base_now;
            cont_reg <= cont_now;
        end
        if (cmd.div)
        begin
            size_reg <= size_div;
        end
        if (cmd.search)
        begin
            for (int i = 0; i < AXES_N; i++)
            begin
                ext_reg[i] <= ext_new[i];
            end
            ofs_reg <= ofs_new;
        end
        if (cmd.next)
        begin
            sym_tot_reg  <= tot_rd;
            sym_low_reg  <= tab_rd[CNT_W-1:0];
            sym_freq_reg <= tab_rd[2*CNT_W-1:CNT_W];
            chunk_reg    <= tab_rd[ENTRY_W-1:2*CNT_W];
            lvl_reg      <= lvl_reg + LVL_W'(1);
        end
        if (cmd.res_step)
        begin
            res_axis_reg <= res_axis_reg + AX_W'(1);
        end
    end

    // residual offset on the current axis
    logic signed [EXT_W-1:0] res_diff;
    assign res_diff = EXT_W'(c_reg[res_axis_reg]) - ext_reg[res_axis_reg];

    // output register
    logic              out_valid_reg;
    logic              out_last_reg;
    logic [TOT_W-1:0]  out_tot_reg;
    logic [LOW_W-1:0]  out_low_reg;
    logic [FREQ_W-1:0] out_freq_reg;
    logic              out_inr_reg;
    logic              out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_last_reg <= cmd.out_last;
            unique case (cmd.out_sel)
                OSEL_SYM:
                begin
                    out_tot_reg  <= TOT_W'(sym_tot_reg);
                    out_low_reg  <= LOW_W'(sym_low_reg);
                    out_freq_reg <= sym_freq_reg;
                    out_inr_reg  <= 1'b1;
                end
                OSEL_RES:
                begin
                    out_tot_reg  <= size_reg;
                    out_low_reg  <= res_diff[LOW_W-1:0];
                    out_freq_reg <= FREQ_W'(1);
                    out_inr_reg  <= 1'b1;
                end
                default:
                begin
                    out_tot_reg  <= '0;
                    out_low_reg  <= '0;
                    out_freq_reg <= '0;
                    out_inr_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'b0, out_inr_reg, out_freq_reg, out_low_reg, out_tot_reg};

    // status
    always_comb
    begin
        stat.div_last = (dcnt_reg == DIV_LAST);
        stat.in_ok    = in_ok;
        stat.cont     = cont_reg;
        stat.size_gt1 = (size_reg > SIZE_W'(1));
        stat.res_last = (res_axis_reg == (axes_eff - AX_W'(1)));
        stat.out_free = out_free;
    end

endmodule
